FILE: rtl/kmer_bucket_hash_top_defines.svh
// Assertion macros for the kmer bucket hash block.
`ifndef KMER_BUCKET_HASH_TOP_DEFINES_SVH
`define KMER_BUCKET_HASH_TOP_DEFINES_SVH

// Same-cycle implication, off during reset.
`define KBH_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("kbh same-cycle check failed");

// Next-cycle implication, off during reset.
`define KBH_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("kbh next-cycle check failed");

// Next-cycle implication, checked through reset as well.
`define KBH_ASSERT_NEXT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("kbh reset check failed");

`endif

FILE: rtl/kbh_pkg.sv
// Shared types, constants and helper functions for the kmer bucket hash.
package kbh_pkg;

   localparam int SizeBits   = 50;
   localparam int WordBits   = 64;
   localparam int CharBits   = 8;
   localparam int CountBits  = 6;
   localparam int QueueDepth = 2;

   localparam logic [CountBits-1:0] HeadChars = CountBits'(32);
   localparam logic [SizeBits-1:0]  SizeReset = SizeBits'(3359);
   localparam logic [WordBits-1:0]  AccReset  = WordBits'(1);

   typedef struct packed {
      logic [WordBits-1:0] head;
      logic [WordBits-1:0] tail;
   } job_type;

   // Two-bit nucleotide code from a character byte.
   function automatic logic [1:0] char_code(input logic [CharBits-1:0] ch);
      return ch[2:1];
   endfunction

   // One restoring step of a remainder by m: shift in one bit, subtract once.
   function automatic logic [SizeBits-1:0] mod_step(input logic [SizeBits-1:0] rem,
                                                    input logic              bit_in,
                                                    input logic [SizeBits-1:0] m);
      logic [SizeBits:0] t;
      t = {rem, bit_in};
      if (t >= {1'b0, m}) begin
         t = t - {1'b0, m};
      end
      return t[SizeBits-1:0];
   endfunction

endpackage

FILE: rtl/kmer_bucket_hash_top.sv
// Throughput: one character item per cycle into the packer while the job queue has room;
// the reduction back end takes one key at a time (two 64-step remainders in parallel,
// a 50-step shift-add product, one more 64-step remainder, one load and one handoff).
// Reset: synchronous, active high; sets the accumulators to one, empties the queue, idles the
// back end, drops the output valid and sets table_size to 3359.
module kmer_bucket_hash_top #(
   parameter int QUEUE_DEPTH = kbh_pkg::QueueDepth
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_en,
   input  logic [kbh_pkg::SizeBits-1:0]  csr_table_size,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [kbh_pkg::CharBits-1:0]  req_character,
   input  logic                          req_last_char,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [kbh_pkg::SizeBits-1:0]  rsp_bucket_index
);
   import kbh_pkg::*;

   logic [SizeBits-1:0] table_size_ff;
   logic                accept;
   logic                job_push, job_pop, job_full, job_empty;
   job_type             push_job, pop_job;
   logic                rsp_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= SizeReset;
      end else if (csr_write_en) begin
         table_size_ff <= csr_table_size;
      end
   end

   assign req_full  = job_full;
   assign accept    = req_push && !job_full;
   assign rsp_empty = !rsp_valid;

   kbh_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .character (req_character),
      .last_char (req_last_char),
      .job_push  (job_push),
      .job       (push_job)
   );

   kbh_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .pop      (job_pop),
      .pop_job  (pop_job),
      .full     (job_full),
      .empty    (job_empty)
   );

   kbh_back u_back (
      .clock            (clock),
      .reset            (reset),
      .table_size       (table_size_ff),
      .job_empty        (job_empty),
      .job              (pop_job),
      .job_pop          (job_pop),
      .rsp_valid        (rsp_valid),
      .rsp_pop          (rsp_pop),
      .rsp_bucket_index (rsp_bucket_index)
   );

endmodule

FILE: rtl/kbh_front.sv
// Front end: packs key characters into the head and tail accumulators.
module kbh_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [kbh_pkg::CharBits-1:0]   character,
   input  logic                           last_char,
   output logic                           job_push,
   output kbh_pkg::job_type               job
);
   import kbh_pkg::*;

   logic [WordBits-1:0]  head_ff, head_in;
   logic [WordBits-1:0]  tail_ff, tail_in;
   logic [CountBits-1:0] seen_ff, seen_in;
   logic [WordBits-1:0]  head_next, tail_next;
   logic                 in_head;

   assign in_head   = seen_ff < HeadChars;
   assign head_next = in_head ? {head_ff[WordBits-3:0], char_code(character)} : head_ff;
   assign tail_next = in_head ? tail_ff : {tail_ff[WordBits-3:0], char_code(character)};

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      seen_in = seen_ff;
      if (accept) begin
         if (last_char) begin
            head_in = AccReset;
            tail_in = AccReset;
            seen_in = '0;
         end else begin
            head_in = head_next;
            tail_in = tail_next;
            seen_in = in_head ? seen_ff + CountBits'(1) : seen_ff;
         end
      end
   end

   assign job_push  = accept && last_char;
   assign job.head  = head_next;
   assign job.tail  = tail_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= AccReset;
         tail_ff <= AccReset;
         seen_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         seen_ff <= seen_in;
      end
   end

endmodule

FILE: rtl/kbh_queue.sv
// Short job queue between the packing front end and the reduction back end.
module kbh_queue #(
   parameter int DEPTH = kbh_pkg::QueueDepth
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  kbh_pkg::job_type push_job,
   input  logic             pop,
   output kbh_pkg::job_type pop_job,
   output logic             full,
   output logic             empty
);
   import kbh_pkg::*;

   localparam int PtrBits   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CountBitsQ = $clog2(DEPTH + 1);

   job_type               mem_ff [DEPTH];
   logic [PtrBits-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CountBitsQ-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign full    = count_ff == CountBitsQ'(DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_job = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrBits'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrBits'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrBits'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrBits'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CountBitsQ'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CountBitsQ'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

FILE: rtl/kbh_back.sv
// Back end: sequential modular reduction and wrapped product per key.
module kbh_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [kbh_pkg::SizeBits-1:0]  table_size,
   input  logic                          job_empty,
   input  kbh_pkg::job_type              job,
   output logic                          job_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_pop,
   output logic [kbh_pkg::SizeBits-1:0]  rsp_bucket_index
);
   import kbh_pkg::*;

   localparam int StateBits = 3;
   localparam logic [StateBits-1:0] StIdle  = 3'd0;
   localparam logic [StateBits-1:0] StModAb = 3'd1;
   localparam logic [StateBits-1:0] StMul   = 3'd2;
   localparam logic [StateBits-1:0] StModP  = 3'd3;
   localparam logic [StateBits-1:0] StDone  = 3'd4;

   localparam int StepBits = $clog2(WordBits);

   logic [StateBits-1:0] state_ff, state_in;
   logic [StepBits-1:0]  step_ff, step_in;
   logic [WordBits-1:0]  num_a_ff, num_a_in;
   logic [WordBits-1:0]  num_b_ff, num_b_in;
   logic [SizeBits-1:0]  rem_a_ff, rem_a_in;
   logic [SizeBits-1:0]  rem_b_ff, rem_b_in;
   logic [WordBits-1:0]  prod_ff, prod_in;
   logic                 valid_ff, valid_in;
   logic [SizeBits-1:0]  index_ff, index_in;
   logic [WordBits-1:0]  prod_sum;
   logic                 word_end, size_end;

   // MSB-first shift-add, wraps at the word width.
   assign prod_sum = {prod_ff[WordBits-2:0], 1'b0}
                   + (rem_b_ff[SizeBits-1] ? WordBits'(rem_a_ff) : '0);
   assign word_end = step_ff == StepBits'(WordBits - 1);
   assign size_end = step_ff == StepBits'(SizeBits - 1);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      num_a_in = num_a_ff;
      num_b_in = num_b_ff;
      rem_a_in = rem_a_ff;
      rem_b_in = rem_b_ff;
      prod_in  = prod_ff;
      valid_in = valid_ff;
      index_in = index_ff;
      job_pop  = 1'b0;
      if (rsp_pop && valid_ff) begin
         valid_in = 1'b0;
      end
      unique case (state_ff)
         StIdle: begin
            if (!job_empty) begin
               job_pop  = 1'b1;
               num_a_in = job.head;
               num_b_in = job.tail;
               rem_a_in = '0;
               rem_b_in = '0;
               step_in  = '0;
               state_in = StModAb;
            end
         end
         StModAb: begin
            rem_a_in = mod_step(rem_a_ff, num_a_ff[WordBits-1], table_size);
            rem_b_in = mod_step(rem_b_ff, num_b_ff[WordBits-1], table_size);
            num_a_in = {num_a_ff[WordBits-2:0], 1'b0};
            num_b_in = {num_b_ff[WordBits-2:0], 1'b0};
            step_in  = step_ff + StepBits'(1);
            if (word_end) begin
               step_in  = '0;
               prod_in  = '0;
               state_in = StMul;
            end
         end
         StMul: begin
            prod_in  = prod_sum;
            rem_b_in = {rem_b_ff[SizeBits-2:0], 1'b0};
            step_in  = step_ff + StepBits'(1);
            if (size_end) begin
               num_a_in = prod_sum;
               rem_a_in = '0;
               step_in  = '0;
               state_in = StModP;
            end
         end
         StModP: begin
            rem_a_in = mod_step(rem_a_ff, num_a_ff[WordBits-1], table_size);
            num_a_in = {num_a_ff[WordBits-2:0], 1'b0};
            step_in  = step_ff + StepBits'(1);
            if (word_end) begin
               state_in = StDone;
            end
         end
         StDone: begin
            if (!valid_ff || rsp_pop) begin
               valid_in = 1'b1;
               index_in = (table_size == '0) ? '0 : rem_a_ff;
               state_in = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   assign rsp_valid        = valid_ff;
   assign rsp_bucket_index = index_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      num_a_ff <= num_a_in;
      num_b_ff <= num_b_in;
      rem_a_ff <= rem_a_in;
      rem_b_ff <= rem_b_in;
      prod_ff  <= prod_in;
      index_ff <= index_in;
   end

endmodule

FILE: rtl/kbh_checker.sv
// Port-level checks for the kmer bucket hash, bound to the top level.
`include "kmer_bucket_hash_top_defines.svh"

module kbh_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          csr_write_en,
   input logic [kbh_pkg::SizeBits-1:0]  csr_table_size,
   input logic                          rsp_empty,
   input logic                          rsp_pop,
   input logic [kbh_pkg::SizeBits-1:0]  rsp_bucket_index
);
   import kbh_pkg::*;

   logic [SizeBits-1:0] size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SizeReset;
      end else if (csr_write_en) begin
         size_ff <= csr_table_size;
      end
   end

   `KBH_ASSERT_NEXT_ALWAYS(a_reset_empty, reset, rsp_empty)
   `KBH_ASSERT_NEXT(a_hold, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_bucket_index))
   `KBH_ASSERT_IMPLY(a_range, !rsp_empty && size_ff != '0, rsp_bucket_index < size_ff)
   `KBH_ASSERT_IMPLY(a_zero_size, !rsp_empty && size_ff == '0, rsp_bucket_index == '0)

endmodule

bind kmer_bucket_hash_top kbh_checker u_kbh_checker (.*);
